>>> design/ppc_rp_pkg.sv
// Shared types and constants for the PowerPC relocation patcher.
// Holds the channel payload structs, opcode/status/register codes and stub words.
// No dependencies; every other design file imports this package.
package ppc_rp_pkg;

   // Relocation opcodes
   localparam logic [3:0] OP_NONE   = 4'd0;
   localparam logic [3:0] OP_ADDR32 = 4'd1;
   localparam logic [3:0] OP_LO     = 4'd2;
   localparam logic [3:0] OP_HI     = 4'd3;
   localparam logic [3:0] OP_HA     = 4'd4;
   localparam logic [3:0] OP_DTPMOD = 4'd5;
   localparam logic [3:0] OP_DTPREL = 4'd6;
   localparam logic [3:0] OP_REL_HA = 4'd7;
   localparam logic [3:0] OP_REL_HI = 4'd8;
   localparam logic [3:0] OP_REL_LO = 4'd9;
   localparam logic [3:0] OP_REL14  = 4'd10;
   localparam logic [3:0] OP_REL24  = 4'd11;

   // Result status codes
   localparam logic [2:0] STS_OK          = 3'd0;
   localparam logic [2:0] STS_UNSUPPORTED = 3'd1;
   localparam logic [2:0] STS_REL14_RANGE = 3'd2;
   localparam logic [2:0] STS_MISALIGNED  = 3'd3;
   localparam logic [2:0] STS_SIGN_BITS   = 3'd4;
   localparam logic [2:0] STS_NO_POOL     = 3'd5;
   localparam logic [2:0] STS_POOL_FULL   = 3'd6;
   localparam logic [2:0] STS_TRAMP_FAR   = 3'd7;

   // Configuration register indexes
   localparam logic [1:0] CSR_TRAMP_BASE   = 2'd0;
   localparam logic [1:0] CSR_TRAMP_STRIDE = 2'd1;
   localparam logic [1:0] CSR_SLOTS_IN_USE = 2'd2;

   localparam logic [31:0] TRAMP_BASE_RESET   = 32'd0;
   localparam logic [8:0]  TRAMP_STRIDE_RESET = 9'd20;
   localparam logic [6:0]  SLOTS_RESET        = 7'd0;

   // Branch reach limits and field masks
   localparam logic signed [31:0] REACH14 = 32'sh0000_7FFC;
   localparam logic signed [31:0] REACH24 = 32'sh01FF_FFFC;
   localparam logic [31:0] HA_ROUND   = 32'h0000_8000;
   localparam logic [31:0] KEEP14     = 32'hFFBF_0003;
   localparam logic [31:0] DISP14     = 32'h0000_FFFC;
   localparam logic [31:0] KEEP24     = 32'hFC00_0003;
   localparam logic [31:0] DISP24     = 32'h03FF_FFFC;

   // Trampoline stub: lis r11 / ori r11 / mtctr r11 / bctr
   localparam logic [31:0] STUB_LIS   = 32'h3D60_0000;
   localparam logic [31:0] STUB_ORI   = 32'h616B_0000;
   localparam logic [31:0] STUB_MTCTR = 32'h7D69_03A6;
   localparam logic [31:0] STUB_BCTR  = 32'h4E80_0420;
   localparam logic [2:0]  STUB_BEATS = 3'd4;

   typedef struct packed {
      logic [3:0]         opcode;
      logic [31:0]        offset;
      logic signed [31:0] addend;
      logic [31:0]        section_base;
      logic [31:0]        symbol_address;
      logic [31:0]        target_word;
      logic               fixed_kind;
   } req_type;

   typedef struct packed {
      logic        write_enable;
      logic [31:0] write_address;
      logic [31:0] write_data;
      logic        write_halfword;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       capture;
      logic       eval1;
      logic       eval2;
      logic       load_out;
      logic       claim;
      logic [2:0] beat_idx;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic use_stubs;
   } dp_status_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_EVAL1 = 4'b0010,
      ST_EVAL2 = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

endpackage

>>> design/ppc_relocation_patcher_unit.sv
// Top level of the PowerPC relocation patcher.
// Instantiates ppc_rp_control and ppc_rp_datapath; types from ppc_rp_pkg.
//
// Usage:
//  - req channel (valid/ready) takes one relocation entry per beat; rsp
//    channel (valid/ready) returns the memory writes that patch it, with
//    last set on the final beat of each entry.
//  - csr port: write csr_wdata to register csr_index when csr_we is high
//    (0 trampoline base, 1 slot stride, 2 slots provided). Write only while idle.
//  - One entry is handled at a time. The first result beat is loaded after
//    the entry is accepted, once the evaluation states EVAL1 and EVAL2 have
//    done the distance and trampoline address adds, into the result
//    register; req_ready returns the cycle after the last beat loads.
//    A plain entry gives one beat; a trampolined 24-bit branch gives four
//    stub beats plus the branch beat.
//  - A stalled receiver holds the result register; the sequencer waits
//    with the next beat until the register frees up.
//  - Reset returns the sequencer to idle, empties the result register,
//    loads the default registers and marks every trampoline slot free
//    (the pool count returns to zero in the same cycle).
module ppc_relocation_patcher_unit #(
   parameter int NUM_SLOTS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ppc_rp_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ppc_rp_pkg::rsp_type rsp_data,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata
);
   import ppc_rp_pkg::*;

   cmd_type       cmd;
   dp_status_type sts;

   // Sequencer: idle -> EVAL1 -> EVAL2 -> one beat per free output slot
   ppc_rp_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Arithmetic, pool count, configuration and result register
   ppc_rp_datapath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

>>> design/ppc_rp_datapath.sv
// Datapath of the relocation patcher: entry registers, address arithmetic,
// trampoline pool count, configuration registers and the result register.
// Depends on ppc_rp_pkg.
module ppc_rp_datapath #(
   parameter int NUM_SLOTS = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ppc_rp_pkg::req_type          req_data,
   input  ppc_rp_pkg::cmd_type          cmd,
   output ppc_rp_pkg::dp_status_type    sts,
   output ppc_rp_pkg::rsp_type          rsp_data,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [31:0]                  csr_wdata
);
   import ppc_rp_pkg::*;

   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam int XW = (CW > 7) ? CW : 7;
   localparam int PW = CW + 9;

   logic [31:0] tbase_ff;
   logic [8:0]  stride_ff;
   logic [6:0]  slots_ff;
   logic [CW-1:0] fill_ff, fill_in;

   logic [3:0]  op_ff;
   logic [31:0] addend_ff, tw_ff, target_ff, value_ff, prod_ff;
   logic [31:0] rel_ff, saddr_ff, at_ff, ndist_ff;
   rsp_type     rsp_data_ff, beat;

   logic [PW-1:0] prod_w;
   logic [XW-1:0] slots_x, limit_x, n_eff, fill_x;
   logic          no_pool, pool_full, far24, tramp_far, range14_bad;
   logic [31:0]   r24, ha_val, ha_rel;
   rsp_type       fin, stub;

   assign prod_w = fill_ff * stride_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tbase_ff  <= TRAMP_BASE_RESET;
         stride_ff <= TRAMP_STRIDE_RESET;
         slots_ff  <= SLOTS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TRAMP_BASE:   tbase_ff  <= csr_wdata;
            CSR_TRAMP_STRIDE: stride_ff <= csr_wdata[8:0];
            CSR_SLOTS_IN_USE: slots_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   // Slots are never freed and always claimed lowest first, so the claimed
   // set is a prefix of the pool: a fill count is the whole slot table.
   assign fill_in = cmd.claim ? fill_ff + CW'(1) : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_data.opcode;
         addend_ff <= req_data.addend;
         tw_ff     <= req_data.target_word;
         target_ff <= req_data.section_base + req_data.offset;
         value_ff  <= req_data.symbol_address + req_data.addend;
         prod_ff   <= 32'(prod_w);
      end
      if (cmd.eval1) begin
         rel_ff   <= value_ff - target_ff;
         saddr_ff <= tbase_ff + prod_ff;
         at_ff    <= addend_ff - target_ff;
      end
      if (cmd.eval2) begin
         ndist_ff <= saddr_ff + at_ff;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= beat;
      end
   end

   assign slots_x   = XW'(slots_ff);
   assign limit_x   = XW'(NUM_SLOTS);
   assign n_eff     = (slots_x > limit_x) ? limit_x : slots_x;
   assign fill_x    = XW'(fill_ff);
   assign no_pool   = (n_eff == '0);
   assign pool_full = (fill_x >= n_eff);

   assign far24 = ($signed(rel_ff) > REACH24) || ($signed(rel_ff) < -REACH24);
   assign tramp_far = ($signed(ndist_ff) > REACH24) || ($signed(ndist_ff) < -REACH24);
   assign range14_bad = ($signed(rel_ff) > REACH14) || ($signed(rel_ff) < -REACH14);

   assign sts.use_stubs = (op_ff == OP_REL24) && far24 && !no_pool && !pool_full
                          && !tramp_far;
   assign r24    = sts.use_stubs ? ndist_ff : rel_ff;
   assign ha_val = value_ff + HA_ROUND;
   assign ha_rel = rel_ff + HA_ROUND;

   // Final beat of an entry
   always_comb begin
      fin = '0;
      fin.last = 1'b1;
      case (op_ff)
         OP_NONE, OP_DTPMOD: fin.status = STS_OK;
         OP_ADDR32, OP_DTPREL: begin
            fin.write_enable  = 1'b1;
            fin.write_address = target_ff;
            fin.write_data    = value_ff;
         end
         OP_LO, OP_HI, OP_HA, OP_REL_HA, OP_REL_HI, OP_REL_LO: begin
            fin.write_enable   = 1'b1;
            fin.write_address  = target_ff;
            fin.write_halfword = 1'b1;
            case (op_ff)
               OP_LO:     fin.write_data = {16'h0, value_ff[15:0]};
               OP_HI:     fin.write_data = {16'h0, value_ff[31:16]};
               OP_HA:     fin.write_data = {16'h0, ha_val[31:16]};
               OP_REL_HA: fin.write_data = {16'h0, ha_rel[31:16]};
               OP_REL_HI: fin.write_data = {16'h0, rel_ff[31:16]};
               default:   fin.write_data = {16'h0, rel_ff[15:0]};
            endcase
         end
         OP_REL14: begin
            if (range14_bad) begin
               fin.status = STS_REL14_RANGE;
            end else if (rel_ff[1:0] != 2'b00) begin
               fin.status = STS_MISALIGNED;
            end else if (rel_ff[31:15] != {17{rel_ff[31]}}) begin
               fin.status = STS_SIGN_BITS;
            end else begin
               fin.write_enable  = 1'b1;
               fin.write_address = target_ff;
               fin.write_data    = (tw_ff & KEEP14) | (rel_ff & DISP14);
            end
         end
         OP_REL24: begin
            if (far24 && no_pool) begin
               fin.status = STS_NO_POOL;
            end else if (far24 && pool_full) begin
               fin.status = STS_POOL_FULL;
            end else if (far24 && tramp_far) begin
               fin.status = STS_TRAMP_FAR;
            end else if (r24[1:0] != 2'b00) begin
               fin.status = STS_MISALIGNED;
            end else if (r24[31:25] != {7{r24[31]}}) begin
               fin.status = STS_SIGN_BITS;
            end else begin
               fin.write_enable  = 1'b1;
               fin.write_address = target_ff;
               fin.write_data    = (tw_ff & KEEP24) | (r24 & DISP24);
            end
         end
         default: fin.status = STS_UNSUPPORTED;
      endcase
   end

   // Stub words, one per beat
   always_comb begin
      stub = '0;
      stub.write_enable  = 1'b1;
      stub.write_address = saddr_ff + {27'd0, cmd.beat_idx[1:0], 3'd0} / 32'd2;
      case (cmd.beat_idx[1:0])
         2'd0:    stub.write_data = STUB_LIS | {16'h0, value_ff[31:16]};
         2'd1:    stub.write_data = STUB_ORI | {16'h0, value_ff[15:0]};
         2'd2:    stub.write_data = STUB_MTCTR;
         default: stub.write_data = STUB_BCTR;
      endcase
   end

   assign beat     = (sts.use_stubs && !cmd.beat_idx[2]) ? stub : fin;
   assign rsp_data = rsp_data_ff;

endmodule

>>> design/ppc_rp_control.sv
// Controller of the relocation patcher: sequences capture, evaluation and
// result beats, and owns the result valid flag. Depends on ppc_rp_pkg.
module ppc_rp_control (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  ppc_rp_pkg::dp_status_type sts,
   output ppc_rp_pkg::cmd_type       cmd
);
   import ppc_rp_pkg::*;

   state_type  state_ff, state_in;
   logic [2:0] beat_ff, beat_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free, final_beat;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign final_beat = !sts.use_stubs || (beat_ff == STUB_BEATS);

   always_comb begin
      cmd          = '0;
      cmd.beat_idx = beat_ff;
      state_in     = state_ff;
      beat_in      = beat_ff;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL1;
            end
         end
         ST_EVAL1: begin
            cmd.eval1 = 1'b1;
            state_in  = ST_EVAL2;
         end
         ST_EVAL2: begin
            cmd.eval2 = 1'b1;
            beat_in   = 3'd0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               if (final_beat) begin
                  cmd.claim = sts.use_stubs;
                  state_in  = ST_IDLE;
               end else begin
                  beat_in = beat_ff + 3'd1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         beat_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> tb/sv/tb_ppc_relocation_patcher_unit.sv
// Self-checking testbench for ppc_relocation_patcher_unit: directed and random relocation
// entries, each write beat compared against an in-bench prediction of the patch writes.
// Depends on ppc_rp_pkg for payload types, opcode/status/register codes and stub words.
module tb_ppc_relocation_patcher_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import ppc_rp_pkg::*;

   localparam int NUM_SLOTS    = 64;
   localparam int NUM_OPCODES  = 16;
   // Longest stretch with no beat on either channel before the run is declared hung
   localparam int QUIET_LIMIT  = 2000;
   // Cycles to hold off after the last beat before touching the registers
   localparam int HOLD_OFF     = 4;
   // Cycles to watch for stray beats once everything predicted has arrived
   localparam int DRAIN_CYCLES = 8;
   localparam int MAX_PRINTED  = 40;
   localparam logic [31:0] SIGN14_MASK = 32'hFFFF_8000;
   localparam logic [31:0] SIGN24_MASK = 32'hFE00_0000;
   // Smallest word-aligned forward displacement a 24-bit branch cannot reach
   localparam logic [31:0] FAR_MIN     = 32'h0200_0000;

   typedef enum bit [1:0] {SLOT_FREE, SLOT_FIXED, SLOT_IMPORT} slot_state_type;

   // Shadow of the block: register copies, trampoline slot table and the
   // write beats still owed by the block, oldest first.
   class reloc_patch_book;
      logic [31:0] tramp_base;
      logic [8:0]  tramp_stride;
      logic [6:0]  pool_size;
      slot_state_type slot_state[NUM_SLOTS];
      rsp_type     pending_writes[$];
      int          errors;

      function new();
         tramp_base   = TRAMP_BASE_RESET;
         tramp_stride = TRAMP_STRIDE_RESET;
         pool_size    = SLOTS_RESET;
         foreach (slot_state[i]) slot_state[i] = SLOT_FREE;
         errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            CSR_TRAMP_BASE:   tramp_base   = val;
            CSR_TRAMP_STRIDE: tramp_stride = val[8:0];
            CSR_SLOTS_IN_USE: pool_size    = val[6:0];
            default: ;
         endcase
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= MAX_PRINTED) $display("[%0t] %s", $time, msg);
      endfunction

      function void queue_write(logic we, logic [31:0] addr, logic [31:0] data,
                                logic half, logic [2:0] sts, logic last);
         rsp_type w;
         w.write_enable   = we;
         w.write_address  = addr;
         w.write_data     = data;
         w.write_halfword = half;
         w.status         = sts;
         w.last           = last;
         pending_writes.push_back(w);
      endfunction

      function void queue_fault(logic [2:0] sts);
         queue_write(1'b0, '0, '0, 1'b0, sts, 1'b1);
      endfunction

      // Predict the writes of one accepted entry and claim a slot if it trampolines
      function void note_entry(req_type r);
         logic [31:0] target, value, rel, rounded, slot_addr;
         int span, n, slot, i;
         target = r.section_base + r.offset;
         value  = r.symbol_address + r.addend;
         rel    = value - target;
         span   = $signed(rel);
         case (r.opcode)
            OP_NONE, OP_DTPMOD: queue_fault(STS_OK);
            OP_ADDR32, OP_DTPREL: queue_write(1'b1, target, value, 1'b0, STS_OK, 1'b1);
            OP_LO: queue_write(1'b1, target, {16'h0, value[15:0]}, 1'b1, STS_OK, 1'b1);
            OP_HI: queue_write(1'b1, target, {16'h0, value[31:16]}, 1'b1, STS_OK, 1'b1);
            OP_HA: begin
               rounded = value + HA_ROUND;
               queue_write(1'b1, target, {16'h0, rounded[31:16]}, 1'b1, STS_OK, 1'b1);
            end
            OP_REL_HA: begin
               rounded = rel + HA_ROUND;
               queue_write(1'b1, target, {16'h0, rounded[31:16]}, 1'b1, STS_OK, 1'b1);
            end
            OP_REL_HI: queue_write(1'b1, target, {16'h0, rel[31:16]}, 1'b1, STS_OK, 1'b1);
            OP_REL_LO: queue_write(1'b1, target, {16'h0, rel[15:0]}, 1'b1, STS_OK, 1'b1);
            OP_REL14: begin
               if (span > REACH14 || span < -REACH14) queue_fault(STS_REL14_RANGE);
               else if (rel[1:0] != 2'b00) queue_fault(STS_MISALIGNED);
               else if (span >= 0 ? (rel & SIGN14_MASK) != '0
                                  : (rel & SIGN14_MASK) != SIGN14_MASK)
                  queue_fault(STS_SIGN_BITS);
               else
                  queue_write(1'b1, target, (r.target_word & KEEP14) | (rel & DISP14),
                              1'b0, STS_OK, 1'b1);
            end
            OP_REL24: begin
               if (span > REACH24 || span < -REACH24) begin
                  n = (pool_size > NUM_SLOTS) ? NUM_SLOTS : pool_size;
                  if (n == 0) begin
                     queue_fault(STS_NO_POOL);
                     return;
                  end
                  slot = n;
                  for (i = n - 1; i >= 0; i--)
                     if (slot_state[i] == SLOT_FREE) slot = i;
                  if (slot >= n) begin
                     queue_fault(STS_POOL_FULL);
                     return;
                  end
                  slot_addr = tramp_base + slot * tramp_stride;
                  rel  = slot_addr + r.addend - target;
                  span = $signed(rel);
                  if (span > REACH24 || span < -REACH24) begin
                     queue_fault(STS_TRAMP_FAR);
                     return;
                  end
                  queue_write(1'b1, slot_addr, STUB_LIS | {16'h0, value[31:16]},
                              1'b0, STS_OK, 1'b0);
                  queue_write(1'b1, slot_addr + 32'd4, STUB_ORI | {16'h0, value[15:0]},
                              1'b0, STS_OK, 1'b0);
                  queue_write(1'b1, slot_addr + 32'd8, STUB_MTCTR, 1'b0, STS_OK, 1'b0);
                  queue_write(1'b1, slot_addr + 32'd12, STUB_BCTR, 1'b0, STS_OK, 1'b0);
                  slot_state[slot] = r.fixed_kind ? SLOT_FIXED : SLOT_IMPORT;
               end
               if (rel[1:0] != 2'b00) queue_fault(STS_MISALIGNED);
               else if (span < 0 ? (rel & SIGN24_MASK) != SIGN24_MASK
                                 : (rel & SIGN24_MASK) != '0)
                  queue_fault(STS_SIGN_BITS);
               else
                  queue_write(1'b1, target, (r.target_word & KEEP24) | (rel & DISP24),
                              1'b0, STS_OK, 1'b1);
            end
            default: queue_fault(STS_UNSUPPORTED);
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) report($sformatf("%s: got %h, want %h", name, got, want));
      endfunction

      // Match one accepted write beat against the oldest prediction
      function void check_write(rsp_type got);
         rsp_type want;
         if (pending_writes.size() == 0) begin
            report($sformatf("write beat with nothing predicted: %h", got));
            return;
         end
         want = pending_writes.pop_front();
         compare_field("write_enable", got.write_enable, want.write_enable);
         compare_field("write_address", got.write_address, want.write_address);
         compare_field("write_data", got.write_data, want.write_data);
         compare_field("write_halfword", got.write_halfword, want.write_halfword);
         compare_field("status", got.status, want.status);
         compare_field("last", got.last, want.last);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_TRAMP_BASE;
   logic [31:0] csr_wdata = '0;

   int idle_pct = 0;      // chance per cycle that the sender holds off
   int stall_pct = 0;     // chance per cycle that the receiver stalls
   int quiet_cycles = 0;  // cycles since the last beat on either channel

   reloc_patch_book book = new();

   ppc_relocation_patcher_unit #(
      .NUM_SLOTS(NUM_SLOTS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Both monitors sample at the edge, before any flop or driver update lands,
   // so they see exactly the handshake that the edge completes.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) book.note_entry(req_data);
      if (!reset && rsp_valid && rsp_ready) book.check_write(rsp_data);
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      // Receiver back-pressure: drop ready at random according to the phase
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Hang detector: nothing moved for far longer than any legal stall
   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("ppc_relocation_patcher_unit: mismatch");
      $finish;
   end

   // Present one entry, optionally after random idle cycles, and hold it
   // until the block takes it. Valid is left high so back-to-back beats
   // need no extra edge.
   task automatic drive_entry(req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every predicted write beat has come back.
   // The first edge lets the monitor note an entry accepted on this step.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.pending_writes.size() != 0) @(posedge clock);
   endtask

   // Drain, let the sequencer go idle, then program all three registers
   // and switch the idling pattern.
   task automatic start_phase(logic [31:0] base, logic [8:0] stride, logic [6:0] slots,
                              int sender_idle, int receiver_stall);
      settle();
      repeat (HOLD_OFF) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_TRAMP_BASE;
      csr_wdata <= base;
      book.set_reg(CSR_TRAMP_BASE, base);
      @(posedge clock);
      csr_index <= CSR_TRAMP_STRIDE;
      csr_wdata <= {23'h0, stride};
      book.set_reg(CSR_TRAMP_STRIDE, {23'h0, stride});
      @(posedge clock);
      csr_index <= CSR_SLOTS_IN_USE;
      csr_wdata <= {25'h0, slots};
      book.set_reg(CSR_SLOTS_IN_USE, {25'h0, slots});
      @(posedge clock);
      csr_we    <= 1'b0;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
   endtask

   // Displacement around a branch reach: exact edges, one step past them,
   // or anywhere in between; mostly word aligned.
   function automatic int pick_disp(int reach);
      int d;
      case ($urandom_range(7))
         0: d = reach;
         1: d = -reach;
         2: d = reach + 4;
         3: d = -reach - 4;
         default: d = int'($urandom_range(2 * reach + 8)) - reach - 4;
      endcase
      if ($urandom_range(3) != 0) d = d & ~3;
      return d;
   endfunction

   // Entry whose symbol lands disp bytes from the target
   function automatic req_type branch_entry(logic [3:0] op, logic [31:0] target,
                                            logic [31:0] disp, logic signed [31:0] addend);
      req_type r;
      r.opcode         = op;
      r.section_base   = $urandom;
      r.offset         = target - r.section_base;
      r.addend         = addend;
      r.symbol_address = target + disp - addend;
      r.target_word    = $urandom;
      r.fixed_kind     = 1'($urandom_range(1));
      return r;
   endfunction

   function automatic req_type scatter_entry(logic [3:0] op);
      req_type r;
      r.opcode         = op;
      r.offset         = $urandom;
      r.addend         = $urandom;
      r.section_base   = $urandom;
      r.symbol_address = $urandom;
      r.target_word    = $urandom;
      r.fixed_kind     = 1'($urandom_range(1));
      return r;
   endfunction

   // Mix: a little noise, plain data relocations, 14-bit branches around
   // their reach, near 24-bit branches, and far 24-bit branches aimed so the
   // trampoline pool is usually within reach.
   function automatic req_type random_entry();
      req_type r;
      logic [31:0] target, disp;
      logic signed [31:0] addend;
      int pick;
      pick = $urandom_range(99);
      if (pick < 10)
         r = scatter_entry(4'($urandom_range(NUM_OPCODES - 1)));
      else if (pick < 35)
         r = scatter_entry(4'($urandom_range(OP_REL_LO)));
      else if (pick < 55)
         r = branch_entry(OP_REL14, $urandom, pick_disp(REACH14), $urandom);
      else if (pick < 75)
         r = branch_entry(OP_REL24, $urandom, pick_disp(REACH24), $urandom);
      else begin
         // Place the branch within 8 MiB of the pool, word aligned to it
         target = book.tramp_base
                + ({$urandom_range(32'h00FF_FFFF)} & ~32'd3) - 32'h0080_0000;
         if ($urandom_range(7) == 0) target = $urandom;
         addend = int'($urandom_range(64)) * 4 - 128;
         if ($urandom_range(7) == 0) addend = addend + $urandom_range(3, 1);
         disp = FAR_MIN + $urandom_range(32'hFC00_0000);
         r = branch_entry(OP_REL24, target, disp, addend);
      end
      return r;
   endfunction

   task automatic run_random(int count, int pause_every);
      for (int k = 0; k < count; k++) begin
         // Hold the sender until the block has answered everything so far
         if (pause_every != 0 && k % pause_every == pause_every - 1) settle();
         drive_entry(random_entry());
      end
   endtask

   initial begin
      req_type r;
      int op;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset values in force: no pool, so far branches must report it.
      // Walk every opcode with the fields at their extremes.
      for (op = 0; op < NUM_OPCODES; op++) begin
         r.opcode         = 4'(op);
         r.offset         = op[0] ? '1 : '0;
         r.addend         = op[1] ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         r.section_base   = op[2] ? '1 : '0;
         r.symbol_address = op[3] ? '1 : 32'h0000_8000;
         r.target_word    = op[0] ? '0 : '1;
         r.fixed_kind     = op[1];
         drive_entry(r);
      end
      // 14-bit branch: both reach edges, one step past, misaligned
      drive_entry(branch_entry(OP_REL14, 32'h0000_1000, REACH14, 32'sd0));
      drive_entry(branch_entry(OP_REL14, 32'h0000_1000, -REACH14, 32'sd0));
      drive_entry(branch_entry(OP_REL14, 32'h0000_1000, REACH14 + 4, 32'sd0));
      drive_entry(branch_entry(OP_REL14, 32'h0000_1000, 32'd2, 32'sd0));
      // 24-bit branch: forward edge, misaligned, and out of reach with no pool
      drive_entry(branch_entry(OP_REL24, 32'h0040_0000, REACH24, 32'sd0));
      drive_entry(branch_entry(OP_REL24, 32'h0040_0000, 32'd1, 32'sd0));
      drive_entry(branch_entry(OP_REL24, 32'h0040_0000, -REACH24 - 4, 32'sd0));

      // Three-slot pool with the tightest stride: pool out of reach, claim
      // then misaligned, two clean trampolines, then the pool runs dry.
      start_phase(32'h0010_0000, 9'd16, 7'd3, 0, 0);
      drive_entry(branch_entry(OP_REL24, 32'h8000_0000, FAR_MIN, 32'sd0));
      drive_entry(branch_entry(OP_REL24, 32'h0010_4000, FAR_MIN, 32'sd2));
      drive_entry(branch_entry(OP_REL24, 32'h0010_4000, 32'hF000_0000, 32'sd0));
      drive_entry(branch_entry(OP_REL24, 32'h0010_4000, FAR_MIN, -32'sd8));
      drive_entry(branch_entry(OP_REL24, 32'h0010_4000, FAR_MIN, 32'sd0));
      run_random(40, 0);

      // Full pool, stride of 256, slot addresses wrapping past the top
      start_phase(32'hFFFF_FF00, 9'd256, 7'd64, 48, 0);
      run_random(60, 0);

      // Partial pool under receiver stalls, sender pausing for a full drain
      start_phase(32'h8000_0000, 9'd20, 7'd40, 0, 48);
      run_random(60, 15);

      // Odd pool base and stride so trampolined branches can turn misaligned; both sides idle
      start_phase(32'hFFFF_FFFF, 9'd255, 7'd64, 36, 36);
      run_random(60, 0);

      // Pool switched off again
      start_phase(32'h0000_0000, 9'd256, 7'd0, 0, 0);
      run_random(60, 0);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.errors == 0)
         $display("ppc_relocation_patcher_unit: match");
      else
         $display("ppc_relocation_patcher_unit: mismatch");
      $finish;
   end
endmodule

>>> filelist.f
design/ppc_rp_pkg.sv
design/ppc_rp_datapath.sv
design/ppc_rp_control.sv
design/ppc_relocation_patcher_unit.sv
tb/sv/tb_ppc_relocation_patcher_unit.sv
